>>> src/brl_pkg.sv
// Shared constants and types for the line rasterizer.
package brl_pkg;

	localparam int DIM_W     = 12;
	localparam int ADDR_W    = 24;
	localparam int AREA_W    = 24;
	localparam int CFG_IDX_W = 1;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd750;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd400;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FB_WIDTH  = 1'b0,
		REG_FB_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		MODE_START = 1'b0,
		MODE_STEP  = 1'b1
	} mode_t;

	typedef struct packed {
		logic last;
		logic active;
	} pix_flags_t;

endpackage

>>> src/brl_step.sv
// Line walker: holds the Bresenham state and produces one pixel per item.
module brl_step #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  logic                         load,
	input  brl_pkg::mode_t               mode,
	input  logic signed [COORD_BITS-1:0] x_start,
	input  logic signed [COORD_BITS-1:0] y_start,
	input  logic signed [COORD_BITS-1:0] x_end,
	input  logic signed [COORD_BITS-1:0] y_end,
	output logic signed [COORD_BITS-1:0] x_s2,
	output logic signed [COORD_BITS-1:0] y_s2,
	output brl_pkg::pix_flags_t          flags_s2
);
	import brl_pkg::*;

	localparam int CW  = COORD_BITS;
	localparam int D_W = CW + 1;
	localparam int E_W = CW + 3;

	logic signed [CW-1:0]  x_q, y_q, x_d, y_d;
	logic signed [E_W-1:0] err_q, err_d;
	logic [D_W-1:0]        adx_q, ady_q, adx_d, ady_d;
	logic                  xneg_q, yneg_q, xmaj_q, xneg_d, yneg_d, xmaj_d;
	logic [D_W-1:0]        rem_q, rem_d;
	logic                  busy_q, busy_d;

	logic signed [D_W-1:0] dx, dy;
	logic [D_W-1:0]        st_adx, st_ady, st_major, st_minor;
	logic [D_W-1:0]        run_major, run_minor;
	logic signed [E_W-1:0] two_min, two_maj;
	logic                  diag;
	logic signed [CW-1:0]  x_inc, y_inc;

	logic signed [CW-1:0]  px, py;
	pix_flags_t            pflags;

	// Setup of a new line.
	assign dx       = D_W'(x_end) - D_W'(x_start);
	assign dy       = D_W'(y_end) - D_W'(y_start);
	assign st_adx   = dx[D_W-1] ? D_W'(-dx) : D_W'(dx);
	assign st_ady   = dy[D_W-1] ? D_W'(-dy) : D_W'(dy);
	assign st_major = (st_adx > st_ady) ? st_adx : st_ady;
	assign st_minor = (st_adx > st_ady) ? st_ady : st_adx;

	// One step of a running line.
	assign run_major = xmaj_q ? adx_q : ady_q;
	assign run_minor = xmaj_q ? ady_q : adx_q;
	assign two_min   = $signed({1'b0, run_minor, 1'b0});
	assign two_maj   = $signed({1'b0, run_major, 1'b0});
	assign diag      = !err_q[E_W-1];
	assign x_inc     = xneg_q ? -CW'(1) : CW'(1);
	assign y_inc     = yneg_q ? -CW'(1) : CW'(1);

	always_comb begin
		x_d    = x_q;
		y_d    = y_q;
		err_d  = err_q;
		adx_d  = adx_q;
		ady_d  = ady_q;
		xneg_d = xneg_q;
		yneg_d = yneg_q;
		xmaj_d = xmaj_q;
		rem_d  = rem_q;
		busy_d = busy_q;
		px     = '0;
		py     = '0;
		pflags = '0;
		case (mode)
			MODE_START: begin
				adx_d  = st_adx;
				ady_d  = st_ady;
				xneg_d = dx[D_W-1];
				yneg_d = dy[D_W-1];
				xmaj_d = st_adx > st_ady;
				err_d  = $signed({1'b0, st_minor, 1'b0}) - $signed({2'b00, st_major});
				rem_d  = st_major;
				x_d    = x_start;
				y_d    = y_start;
				busy_d = st_major != '0;
				px     = x_start;
				py     = y_start;
				pflags = '{last: st_major == '0, active: 1'b1};
			end
			MODE_STEP: begin
				if (busy_q) begin
					err_d  = diag ? (err_q + two_min - two_maj) : (err_q + two_min);
					x_d    = (xmaj_q || diag) ? (x_q + x_inc) : x_q;
					y_d    = (!xmaj_q || diag) ? (y_q + y_inc) : y_q;
					rem_d  = (rem_q > D_W'(1)) ? (rem_q - D_W'(1)) : '0;
					busy_d = rem_q > D_W'(1);
					px     = x_d;
					py     = y_d;
					pflags = '{last: !(rem_q > D_W'(1)), active: 1'b1};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q    <= '0;
			y_q    <= '0;
			err_q  <= '0;
			adx_q  <= '0;
			ady_q  <= '0;
			xneg_q <= 1'b0;
			yneg_q <= 1'b0;
			xmaj_q <= 1'b0;
			rem_q  <= '0;
			busy_q <= 1'b0;
		end else if (fire) begin
			x_q    <= x_d;
			y_q    <= y_d;
			err_q  <= err_d;
			adx_q  <= adx_d;
			ady_q  <= ady_d;
			xneg_q <= xneg_d;
			yneg_q <= yneg_d;
			xmaj_q <= xmaj_d;
			rem_q  <= rem_d;
			busy_q <= busy_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_s2     <= px;
			y_s2     <= py;
			flags_s2 <= pflags;
		end
	end

	// A running line always has steps left.
	a_busy_rem: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q != '0)
		else $error("line in progress with no steps left");

	// A step with no line in progress leaves the walker untouched.
	a_idle_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire && mode == MODE_STEP && !busy_q |=> $stable(x_q) && $stable(y_q) && !busy_q)
		else $error("idle step changed walker state");

	// The final step ends the line and marks its pixel as last.
	a_final_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire && mode == MODE_STEP && busy_q && rem_q == D_W'(1)
		|=> !busy_q && flags_s2.last && flags_s2.active)
		else $error("final step did not end the line");

endmodule

>>> src/brl_addr.sv
// Address stages: row offset product, then linear address and bounds check.
module brl_addr #(
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  logic                          ld_s3,
	input  logic                          ld_out,
	input  logic signed [COORD_BITS-1:0]  x_s2,
	input  logic signed [COORD_BITS-1:0]  y_s2,
	input  brl_pkg::pix_flags_t           flags_s2,
	input  logic [brl_pkg::DIM_W-1:0]     width,
	input  logic [brl_pkg::DIM_W-1:0]     height,
	output logic signed [COORD_BITS-1:0]  x_out_q,
	output logic signed [COORD_BITS-1:0]  y_out_q,
	output logic [brl_pkg::ADDR_W-1:0]    addr_out_q,
	output logic                          we_out_q,
	output brl_pkg::pix_flags_t           flags_out_q
);
	import brl_pkg::*;

	localparam int CW     = COORD_BITS;
	localparam int PROD_W = CW + DIM_W + 1;
	localparam int SUM_W  = (PROD_W + 1 > AREA_W + 2) ? PROD_W + 1 : AREA_W + 2;

	logic signed [CW-1:0]     x_s3, y_s3;
	logic signed [PROD_W-1:0] prod_s3;
	pix_flags_t               flags_s3;
	logic [AREA_W-1:0]        area_q;
	logic signed [SUM_W-1:0]  sum;
	logic                     in_fb;

	// Framebuffer size follows the registers; the user must change them only while idle, as the block does not check.
	always_ff @(posedge clk) begin
		area_q <= AREA_W'(width) * AREA_W'(height);
	end

	always_ff @(posedge clk) begin
		if (ld_s3) begin
			x_s3     <= x_s2;
			y_s3     <= y_s2;
			prod_s3  <= PROD_W'(y_s2) * $signed({1'b0, width});
			flags_s3 <= flags_s2;
		end
	end

	assign sum   = SUM_W'(x_s3) + SUM_W'(prod_s3);
	assign in_fb = !sum[SUM_W-1]
		&& (sum[SUM_W-2:0] < {{(SUM_W-1-AREA_W){1'b0}}, area_q});

	always_ff @(posedge clk) begin
		if (ld_out) begin
			x_out_q     <= x_s3;
			y_out_q     <= y_s3;
			we_out_q    <= flags_s3.active && in_fb;
			addr_out_q  <= (flags_s3.active && in_fb) ? sum[ADDR_W-1:0] : '0;
			flags_out_q <= flags_s3;
		end
	end

endmodule

>>> src/bresenham_line_rasterizer.sv
// Top level of the Bresenham line rasterizer: stream ports, config registers, stages.
//
// The block walks integer Bresenham lines in all octants and delivers one pixel per item.
// A start item (s_tuser = 0) loads two endpoints and returns the first endpoint; each step
// item (s_tuser = 1) moves one pixel along the major axis and returns it, with m_tlast set
// on the end point. Steps after the end return an all-zero item with line_active low.
// Every pixel has the linear address x + y*width, with width the frame width register;
// write_enable is set only when that address lies in 0 .. width*height-1, so an x
// outside a row wraps into a neighboring row; pixel_address carries it only then, else zero.
// One item is taken every clock cycle unless every stage is full and m_tready is low. Each
// result passes through four registers: an input register, the walker step (the whole
// error-term update of one pixel is settled within that stage, which is what lets
// consecutive steps follow each other without gaps), the row-offset multiply and the
// address add with its bounds compare. The stages hold independently, so bubbles close
// up and input is still taken while a finished pixel waits on m_tready and a stage is free.
// Configuration writes are taken at any time but must only be issued with no item
// in flight; register 0 is the frame width, register 1 the frame height (12 bits each).
module bresenham_line_rasterizer #(
	parameter int COORD_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Input item stream.
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// From bit 0: x_start, y_start, x_end, y_end; zero padded to whole bytes.
	input  logic [((4*COORD_BITS+7)/8)*8-1:0]     s_tdata,
	// Bit 0: mode (0 start a line, 1 step one pixel).
	input  logic                                  s_tuser,
	// Result item stream.
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// From bit 0: pixel_x, pixel_y, pixel_address; zero padded to whole bytes.
	output logic [((2*COORD_BITS+24+7)/8)*8-1:0]  m_tdata,
	// last_pixel.
	output logic                                  m_tlast,
	// From bit 0: write_enable, line_active.
	output logic [1:0]                            m_tuser,
	// Configuration write channel.
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [brl_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [brl_pkg::DIM_W-1:0]             cfg_data
);
	import brl_pkg::*;

	localparam int CW    = COORD_BITS;
	localparam int OUT_W = ((2*CW+ADDR_W+7)/8)*8;

	logic [DIM_W-1:0] width_q, height_q;

	logic             v1_q, v2_q, v3_q, vo_q;
	logic             acc1, acc2, acc3, acco;

	mode_t                mode_s1;
	logic signed [CW-1:0] xs_s1, ys_s1, xe_s1, ye_s1;

	logic signed [CW-1:0] x_s2, y_s2;
	pix_flags_t           flags_s2;

	logic signed [CW-1:0] x_o, y_o;
	logic [ADDR_W-1:0]    addr_o;
	logic                 we_o;
	pix_flags_t           flags_o;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_FB_WIDTH:  width_q  <= cfg_data;
				REG_FB_HEIGHT: height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Each stage loads when it is empty or its content moves on.
	assign acco     = !vo_q || m_tready;
	assign acc3     = !v3_q || acco;
	assign acc2     = !v2_q || acc3;
	assign acc1     = !v1_q || acc2;
	assign s_tready = acc1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (acc1) v1_q <= s_tvalid;
			if (acc2) v2_q <= v1_q;
			if (acc3) v3_q <= v2_q;
			if (acco) vo_q <= v3_q;
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (acc1) begin
			mode_s1 <= mode_t'(s_tuser);
			xs_s1   <= s_tdata[CW-1:0];
			ys_s1   <= s_tdata[2*CW-1:CW];
			xe_s1   <= s_tdata[3*CW-1:2*CW];
			ye_s1   <= s_tdata[4*CW-1:3*CW];
		end
	end

	brl_step #(
		.COORD_BITS (COORD_BITS)
	) u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (acc2 && v1_q),
		.load     (acc2),
		.mode     (mode_s1),
		.x_start  (xs_s1),
		.y_start  (ys_s1),
		.x_end    (xe_s1),
		.y_end    (ye_s1),
		.x_s2     (x_s2),
		.y_s2     (y_s2),
		.flags_s2 (flags_s2)
	);

	brl_addr #(
		.COORD_BITS (COORD_BITS)
	) u_addr (
		.clk         (clk),
		.ld_s3       (acc3),
		.ld_out      (acco),
		.x_s2        (x_s2),
		.y_s2        (y_s2),
		.flags_s2    (flags_s2),
		.width       (width_q),
		.height      (height_q),
		.x_out_q     (x_o),
		.y_out_q     (y_o),
		.addr_out_q  (addr_o),
		.we_out_q    (we_o),
		.flags_out_q (flags_o)
	);

	assign m_tvalid = vo_q;
	assign m_tdata  = OUT_W'({addr_o, y_o, x_o});
	assign m_tlast  = flags_o.last;
	assign m_tuser  = {flags_o.active, we_o};

	// Only a produced pixel may be written.
	a_we_active: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tuser[1])
		else $error("write enable on an inactive item");

	// An inactive item carries nothing.
	a_inactive_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[1] |-> m_tdata == '0 && !m_tlast && !m_tuser[0])
		else $error("inactive item carries data");

	// A stage only fills from a valid predecessor.
	a_fill_order: assert property (@(posedge clk) disable iff (!arst_n)
		!v1_q && !v2_q && !v3_q && acco |=> !vo_q)
		else $error("result appeared from an empty pipeline");

endmodule

>>> dv/tb_bresenham_line_rasterizer.sv
// Self-checking testbench for the Bresenham line rasterizer.
`timescale 1ns / 100ps

module tb_bresenham_line_rasterizer;
	import brl_pkg::*;

	localparam int COORD_W  = 16;
	localparam int IN_W     = ((4*COORD_W+7)/8)*8;
	localparam int OUT_W    = ((2*COORD_W+24+7)/8)*8;
	localparam int N_PHASES = 8;
	localparam int PHASE_ITEMS = 168;

	// One input item as the sender queues it.
	typedef struct {
		mode_t                     mode;
		logic signed [COORD_W-1:0] xs, ys, xe, ye;
	} line_item_t;

	// One pixel result, either predicted or observed.
	typedef struct {
		logic signed [COORD_W-1:0] x, y;
		logic [23:0]               addr;
		logic                      we, last, active;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              s_tvalid = 1'b0;
	logic              s_tready;
	// From bit 0: x_start, y_start, x_end, y_end.
	logic [IN_W-1:0]   s_tdata = '0;
	// Bit 0: mode.
	logic              s_tuser = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	// From bit 0: pixel_x, pixel_y, pixel_address.
	logic [OUT_W-1:0]  m_tdata;
	logic              m_tlast;
	// From bit 0: write_enable, line_active.
	logic [1:0]        m_tuser;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DIM_W-1:0]  cfg_data = '0;

	bresenham_line_rasterizer #(.COORD_BITS(COORD_W)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #2 clk = ~clk;

	// Items waiting to be sent, and the pixels the block still owes us.
	line_item_t queued_items[$];
	pixel_t     expected_pixels[$];

	// Shadow copy of the walker: framebuffer size and the line in progress.
	int   fb_width = int'(WIDTH_RESET);
	int   fb_height = int'(HEIGHT_RESET);
	int   walk_x = 0, walk_y = 0, walk_err = 0;
	int   walk_adx = 0, walk_ady = 0, walk_left = 0;
	bit   walk_x_neg = 0, walk_y_neg = 0, walk_x_major = 0, walk_busy = 0;

	int   mismatches = 0;
	int   pixels_checked = 0;
	int   pixels_written = 0;
	int   lines_started = 0;
	int   items_added = 0;

	// Builds the result for the pixel the walker stands on now.
	function automatic pixel_t pixel_here(bit is_last);
		pixel_t p;
		longint a;
		a = longint'(walk_x) + longint'(walk_y) * longint'(fb_width);
		p.x = walk_x[COORD_W-1:0];
		p.y = walk_y[COORD_W-1:0];
		p.we = (a >= 0) && (a < longint'(fb_width) * longint'(fb_height));
		p.addr = p.we ? a[23:0] : '0;
		p.last = is_last;
		p.active = 1'b1;
		return p;
	endfunction

	// Advances the shadow walker by one accepted item and returns its pixel.
	function automatic pixel_t next_pixel(line_item_t it);
		pixel_t p;
		int dx, dy, major, minor;
		p = '{default: '0};
		if (it.mode == MODE_START) begin
			dx = int'(it.xe) - int'(it.xs);
			dy = int'(it.ye) - int'(it.ys);
			walk_adx = dx < 0 ? -dx : dx;
			walk_ady = dy < 0 ? -dy : dy;
			walk_x_neg = it.xe < it.xs;
			walk_y_neg = it.ye < it.ys;
			// Ties go to y, so equal deltas walk the diagonal along y.
			walk_x_major = walk_adx > walk_ady;
			major = walk_x_major ? walk_adx : walk_ady;
			minor = walk_x_major ? walk_ady : walk_adx;
			walk_err = 2 * minor - major;
			walk_left = major;
			walk_x = int'(it.xs);
			walk_y = int'(it.ys);
			walk_busy = major != 0;
			p = pixel_here(major == 0);
		end else if (walk_busy) begin
			major = walk_x_major ? walk_adx : walk_ady;
			minor = walk_x_major ? walk_ady : walk_adx;
			if (walk_err >= 0) begin
				if (walk_x_major)
					walk_y += walk_y_neg ? -1 : 1;
				else
					walk_x += walk_x_neg ? -1 : 1;
				walk_err += 2 * (minor - major);
			end else begin
				walk_err += 2 * minor;
			end
			if (walk_x_major)
				walk_x += walk_x_neg ? -1 : 1;
			else
				walk_y += walk_y_neg ? -1 : 1;
			walk_left--;
			if (walk_left <= 0) begin
				walk_left = 0;
				walk_busy = 0;
			end
			p = pixel_here(!walk_busy);
		end
		// A step with no line in progress leaves every field at zero.
		return p;
	endfunction

	// ------------------------------------------------------------------
	// Sender: bursts of items separated by random gaps. A gap of zero is
	// common, so long back-to-back stretches occur as well.
	// ------------------------------------------------------------------
	logic       in_taken = 1'b0;
	int         burst_left = 0;
	int         gap_left = 0;
	line_item_t send_item;

	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (queued_items.size() > 0) begin
				send_item = queued_items.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= send_item.mode;
				s_tdata <= {send_item.ye, send_item.xe, send_item.ys, send_item.xs};
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: its own pattern, cycling through always ready, light
	// random stalls, heavy random stalls and occasional long stalls.
	// ------------------------------------------------------------------
	int rx_cycle = 0;
	int stall_left = 0;

	always @(negedge clk) begin
		rx_cycle++;
		case ((rx_cycle / 256) % 4)
			0: m_tready <= 1'b1;
			1: m_tready <= $urandom_range(0, 3) != 0;
			2: m_tready <= $urandom_range(0, 1) == 1;
			default: begin
				if (stall_left > 0) begin
					stall_left--;
					m_tready <= 1'b0;
				end else begin
					m_tready <= 1'b1;
					if ($urandom_range(0, 7) == 0)
						stall_left = $urandom_range(1, 12);
				end
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Monitor: tracks register writes, predicts a pixel for every item
	// taken and checks every pixel delivered against the oldest one.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		line_item_t it;
		pixel_t     got, want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FB_WIDTH:  fb_width = int'(cfg_data);
					REG_FB_HEIGHT: fb_height = int'(cfg_data);
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				it.mode = mode_t'(s_tuser);
				it.xs = s_tdata[0*COORD_W +: COORD_W];
				it.ys = s_tdata[1*COORD_W +: COORD_W];
				it.xe = s_tdata[2*COORD_W +: COORD_W];
				it.ye = s_tdata[3*COORD_W +: COORD_W];
				if (it.mode == MODE_START)
					lines_started++;
				expected_pixels = {expected_pixels, next_pixel(it)};
			end
			if (m_tvalid && m_tready) begin
				got.x = m_tdata[0 +: COORD_W];
				got.y = m_tdata[COORD_W +: COORD_W];
				got.addr = m_tdata[2*COORD_W +: 24];
				got.we = m_tuser[0];
				got.active = m_tuser[1];
				got.last = m_tlast;
				if (expected_pixels.size() == 0) begin
					$error("pixel delivered with none outstanding: x %0d y %0d", got.x, got.y);
					mismatches++;
				end else begin
					want = expected_pixels.pop_front();
					pixels_checked++;
					if (got.we === 1'b1)
						pixels_written++;
					if (got.x !== want.x) begin
						$error("pixel_x: expected %0d, got %0d", want.x, got.x);
						mismatches++;
					end
					if (got.y !== want.y) begin
						$error("pixel_y: expected %0d, got %0d", want.y, got.y);
						mismatches++;
					end
					if (got.addr !== want.addr) begin
						$error("pixel_address: expected %0d, got %0d", want.addr, got.addr);
						mismatches++;
					end
					if (got.we !== want.we) begin
						$error("write_enable: expected %0b, got %0b", want.we, got.we);
						mismatches++;
					end
					if (got.last !== want.last) begin
						$error("last_pixel: expected %0b, got %0b", want.last, got.last);
						mismatches++;
					end
					if (got.active !== want.active) begin
						$error("line_active: expected %0b, got %0b", want.active, got.active);
						mismatches++;
					end
				end
			end
			in_taken <= s_tvalid && s_tready;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------
	function automatic int wrap16(int v);
		logic signed [COORD_W-1:0] s;
		s = v[COORD_W-1:0];
		return s;
	endfunction

	function automatic int clamp16(int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	// Any coordinate, with the two extremes picked often.
	function automatic int any_coord();
		case ($urandom_range(0, 3))
			0: return -32768;
			1: return 32767;
			default: return wrap16($urandom);
		endcase
	endfunction

	// A coordinate just around the framebuffer edge on one axis.
	function automatic int near_coord(int lim);
		return int'($urandom_range(0, lim + 8)) - 4;
	endfunction

	task automatic add_item(mode_t m, int xs, int ys, int xe, int ye);
		line_item_t it;
		it.mode = m;
		it.xs = xs[COORD_W-1:0];
		it.ys = ys[COORD_W-1:0];
		it.xe = xe[COORD_W-1:0];
		it.ye = ye[COORD_W-1:0];
		queued_items = {queued_items, it};
		items_added++;
	endtask

	// Step items carry junk in the endpoint fields, which the block ignores.
	task automatic add_steps(int n);
		repeat (n) add_item(MODE_STEP, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic add_line(int xs, int ys, int xe, int ye, int steps);
		add_item(MODE_START, xs, ys, xe, ye);
		add_steps(steps);
	endtask

	// Mostly complete lines with random content near the framebuffer; the
	// rest are lines cut short by a restart, huge lines and plain noise.
	task automatic add_random_line(int w, int h);
		int kind, xs, ys, xe, ye, span, major, steps;
		kind = $urandom_range(0, 19);
		if (kind < 2) begin
			repeat ($urandom_range(1, 3))
				add_item(mode_t'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom);
		end else if (kind < 4) begin
			add_line(any_coord(), any_coord(), any_coord(), any_coord(), $urandom_range(0, 6));
		end else begin
			if ($urandom_range(0, 3) != 0) begin
				xs = near_coord(w);
				ys = near_coord(h);
			end else begin
				xs = any_coord();
				ys = any_coord();
			end
			span = ($urandom_range(0, 4) == 0) ? 60 : 12;
			xe = clamp16(xs + int'($urandom_range(0, 2 * span)) - span);
			ye = clamp16(ys + int'($urandom_range(0, 2 * span)) - span);
			major = (xe > xs ? xe - xs : xs - xe);
			if ((ye > ys ? ye - ys : ys - ye) > major)
				major = ye > ys ? ye - ys : ys - ye;
			steps = major;
			if ($urandom_range(0, 7) == 0)
				steps = $urandom_range(0, major);
			else if ($urandom_range(0, 5) == 0)
				steps = major + $urandom_range(1, 2);
			add_line(xs, ys, xe, ye, steps);
		end
	endtask

	// Waits until every queued item has been sent and every pixel owed has come out,
	// then lets the pipeline settle.
	task automatic wait_for_drain();
		while (queued_items.size() > 0 || s_tvalid || expected_pixels.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, int val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[DIM_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Test sequence. Each phase runs under its own framebuffer size: the
	// reset size first, then single-pixel, full-size, odd sizes, a single
	// row and column, and empty framebuffers of zero width and height.
	// ------------------------------------------------------------------
	int phase_w[N_PHASES] = '{750, 1, 4095, 37, 1, 4095, 0, 64};
	int phase_h[N_PHASES] = '{400, 1, 4095, 23, 4095, 1, 400, 0};

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed lines under the reset framebuffer size.
		add_steps(1);                                // step with no line in progress
		add_line(0, 0, 0, 0, 1);                     // degenerate line, then a dead step
		add_line(10, 10, 15, 12, 6);                 // shallow x-major, one step past the end
		add_line(5, 5, 2, 8, 3);                     // equal deltas, x stepping down
		add_line(-32768, -32768, 32767, 32767, 2);   // extreme endpoints
		add_line(32767, 32767, 32767, -32768, 1);    // restart while a line is running
		add_line(749, 0, 751, 0, 2);                 // x runs off the row and wraps
		add_line(749, 399, 750, 399, 1);             // last framebuffer pixel, then past it

		for (int ph = 0; ph < N_PHASES; ph++) begin
			if (ph > 0) begin
				wait_for_drain();
				write_reg(REG_FB_WIDTH, phase_w[ph]);
				write_reg(REG_FB_HEIGHT, phase_h[ph]);
				@(posedge clk);
			end
			items_added = 0;
			while (items_added < PHASE_ITEMS)
				add_random_line(phase_w[ph], phase_h[ph]);
		end

		wait_for_drain();
		if (expected_pixels.size() != 0) begin
			$error("%0d pixels never delivered", expected_pixels.size());
			mismatches++;
		end
		$display("Checked %0d pixels from %0d line starts over %0d framebuffer sizes,",
			pixels_checked, lines_started, N_PHASES);
		$display("%0d of them inside the framebuffer; %0d mismatches.",
			pixels_written, mismatches);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
